// ===== design/refcounted_page_frame_allocator_defines.svh =====
// assertion macros shared by the allocator rtl
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define RFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rfa_pkg.sv =====
// shared types, codes and helpers of the page frame allocator
package rfa_pkg;

  localparam int ADDR_W      = 21;
  localparam int REG_W       = 9;
  localparam int CMD_W       = 2;
  localparam int BYTES_W     = 16;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int ADDR_MASK   = 2097151;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_USABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_USABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED     = 2'd2;

  localparam logic [REG_W-1:0] FIRST_RESET = 9'd1;
  localparam logic [REG_W-1:0] LAST_RESET  = 9'd511;
  localparam logic [REG_W-1:0] RESV_RESET  = 9'd184;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_ADDREF = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_BAD_ADDR  = 3'd3,
    ST_BAD_COUNT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_LOOK,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_e;

  // page may be handed out under the current window
  function automatic logic page_ok(
    input logic [ADDR_W-1:0] p,
    input logic [REG_W-1:0]  first,
    input logic [REG_W-1:0]  last,
    input logic [REG_W-1:0]  resv,
    input logic [ADDR_W-1:0] lim
  );
    logic [ADDR_W-1:0] f;
    logic [ADDR_W-1:0] l;
    logic [ADDR_W-1:0] r;
    f = ADDR_W'(first);
    l = ADDR_W'(last);
    r = ADDR_W'(resv);
    return (p != '0) && (p <= lim) && (p >= f) && (p <= l) && (p != r);
  endfunction

endpackage

// ===== design/refcounted_page_frame_allocator.sv =====
// top level of the reference counted page frame allocator
// One command is handled at a time. After reset a clearing pass zeroes the
// count memory, during which no command is taken (configuration writes
// are). Allocate scans the count memory one page per cycle from page one
// until a page is granted or memory is out. Free and add reference turn
// the address into a page number with a registered reciprocal multiply,
// then do one read-modify-write of the count memory. Oversize requests,
// null addresses and the unused command go straight to the result.
// A finished result waits in the output register while the next command
// is taken.
`include "refcounted_page_frame_allocator_defines.svh"

module refcounted_page_frame_allocator #(
  parameter int NUM_PAGES  = 512,
  parameter int PAGE_BYTES = 4096,
  parameter int COUNT_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rfa_pkg::REG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rfa_pkg::CMD_W-1:0]         command_i,
  input  logic [rfa_pkg::BYTES_W-1:0]       request_bytes_i,
  input  logic [rfa_pkg::ADDR_W-1:0]        page_address_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rfa_pkg::STATUS_W-1:0]      status_o,
  output logic [rfa_pkg::ADDR_W-1:0]        granted_address_o,
  output logic [rfa_pkg::COUNT_OUT_W-1:0]   count_after_o
);
  import rfa_pkg::*;

  localparam int PW            = $clog2(NUM_PAGES);
  localparam int CW            = COUNT_BITS;
  localparam int MAX_ADDR_PAGE = ADDR_MASK / PAGE_BYTES;
  localparam int LIMIT_PAGE    = (NUM_PAGES - 1 < MAX_ADDR_PAGE) ? NUM_PAGES - 1 : MAX_ADDR_PAGE;
  localparam logic [PW-1:0]     LAST_PAGE = PW'(NUM_PAGES - 1);
  localparam logic [ADDR_W-1:0] LIM       = ADDR_W'(LIMIT_PAGE);
  localparam logic [CW-1:0]     COUNT_MAX = {CW{1'b1}};

  state_e state_q, state_d;

  logic [REG_W-1:0] first_q, last_q, resv_q;

  cmd_e          cmd_in;
  cmd_e          cmd_q;
  logic [PW-1:0] clr_q;
  logic [PW-1:0] scan_q;
  logic          scan_end_q;
  logic          chk_valid_q;
  logic [PW-1:0] chk_page_q;
  logic [PW-1:0] pg_q;

  status_e                res_status_q, res_status_d;
  logic [ADDR_W-1:0]      res_addr_q, res_addr_d;
  logic [COUNT_OUT_W-1:0] res_count_q, res_count_d;

  logic                   out_valid_q;
  status_e                out_status_q;
  logic [ADDR_W-1:0]      out_addr_q;
  logic [COUNT_OUT_W-1:0] out_count_q;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  logic [CW-1:0] mem_rdata;

  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_quot;

  logic              accept;
  logic              out_load;
  logic              too_large;
  logic              look_ok;
  logic [ADDR_W-1:0] chk_page_ext;
  logic              scan_hit;
  logic              scan_last;
  logic [ADDR_W-1:0] grant_addr;
  logic [CW-1:0]     count_new;

  rfa_count_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (CW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rfa_page_div #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (page_address_i),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_in      = cmd_e'(command_i);

  assign too_large    = 32'(request_bytes_i) > PAGE_BYTES;
  assign look_ok      = page_ok(div_quot, first_q, last_q, resv_q, LIM);
  assign chk_page_ext = ADDR_W'(chk_page_q);
  assign scan_hit     = chk_valid_q && (mem_rdata == '0)
                        && page_ok(chk_page_ext, first_q, last_q, resv_q, LIM);
  assign scan_last    = chk_valid_q && (chk_page_q == LAST_PAGE);
  assign grant_addr   = ADDR_W'(chk_page_ext * PAGE_BYTES);

  always_comb begin
    if (cmd_q == CMD_FREE) begin
      count_new = mem_rdata - 1'b1;
    end else if (mem_rdata == COUNT_MAX) begin
      count_new = mem_rdata;
    end else begin
      count_new = mem_rdata + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == LAST_PAGE) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_in) inside
            CMD_ALLOC: state_d = too_large ? S_DONE : S_SCAN;
            CMD_FREE, CMD_ADDREF: state_d = (page_address_i == '0) ? S_DONE : S_DIV;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = look_ok ? S_CHECK : S_DONE;
      end
      S_CHECK: begin
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (scan_hit || scan_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = clr_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = scan_q;
    div_start    = 1'b0;
    out_load     = 1'b0;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_count_d  = res_count_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_count_d  = '0;
          case (cmd_in) inside
            CMD_ALLOC: begin
              if (too_large) res_status_d = ST_TOO_LARGE;
            end
            CMD_FREE, CMD_ADDREF: begin
              if (page_address_i == '0) begin
                if (cmd_in == CMD_ADDREF) res_status_d = ST_BAD_ADDR;
              end else begin
                div_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: ;
      S_LOOK: begin
        if (look_ok) begin
          mem_re    = 1'b1;
          mem_raddr = div_quot[PW-1:0];
        end else begin
          res_status_d = ST_BAD_ADDR;
        end
      end
      S_CHECK: begin
        if (mem_rdata == '0) begin
          res_status_d = ST_BAD_COUNT;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = pg_q;
          mem_wdata   = count_new;
          res_count_d = COUNT_OUT_W'(count_new);
        end
      end
      S_SCAN: begin
        mem_re    = !scan_end_q;
        mem_raddr = scan_q;
        if (scan_hit) begin
          mem_we      = 1'b1;
          mem_waddr   = chk_page_q;
          mem_wdata   = CW'(1);
          res_addr_d  = grant_addr;
          res_count_d = COUNT_OUT_W'(1);
        end else if (scan_last) begin
          res_status_d = ST_OOM;
        end
      end
      S_DONE: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      first_q     <= FIRST_RESET;
      last_q      <= LAST_RESET;
      resv_q      <= RESV_RESET;
      cmd_q       <= CMD_ALLOC;
      scan_q      <= '0;
      scan_end_q  <= 1'b0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_FIRST_USABLE: first_q <= cfg_data_i;
          REG_LAST_USABLE:  last_q  <= cfg_data_i;
          REG_RESERVED:     resv_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        cmd_q       <= cmd_in;
        scan_q      <= PW'(1);
        scan_end_q  <= 1'b0;
        chk_valid_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        chk_valid_q <= mem_re;
        if (mem_re) begin
          scan_q     <= scan_q + 1'b1;
          scan_end_q <= (scan_q == LAST_PAGE);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_count_q  <= res_count_d;
    if (state_q == S_SCAN) chk_page_q <= scan_q;
    if (state_q == S_LOOK) pg_q <= div_quot[PW-1:0];
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_count_q  <= res_count_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;
  assign count_after_o     = out_count_q;

  `RFA_ASSERT_IMP(a_fail_no_payload, out_valid_o && (status_o != ST_OK),
    (granted_address_o == '0) && (count_after_o == '0), "failed beat carries payload")
  `RFA_ASSERT_IMP(a_grant_count_one, out_valid_o && (granted_address_o != '0),
    (status_o == ST_OK) && (count_after_o == COUNT_OUT_W'(1)), "grant without count one")
  `RFA_ASSERT_IMP(a_scan_writes_one, (state_q == S_SCAN) && mem_we,
    mem_wdata == CW'(1), "allocation wrote a count other than one")
  `RFA_ASSERT_NXT(a_one_at_a_time, accept, !in_ready_o, "second command taken while busy")

endmodule

// ===== design/rfa_count_ram.sv =====
// reference count memory, one write and one registered read port
module rfa_count_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rfa_page_div.sv =====
// reciprocal multiply turning a byte address into a page number
module rfa_page_div #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rfa_pkg::ADDR_W-1:0] dividend_i,
  output logic                      done_o,
  output logic [rfa_pkg::ADDR_W-1:0] quotient_o
);
  import rfa_pkg::*;

  localparam int SH  = ADDR_W + $clog2(PAGE_BYTES);
  localparam int RCW = ADDR_W + 2;
  localparam int PRW = ADDR_W + RCW;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES);
  localparam logic [RCW-1:0] RECIP_C = RCW'(RECIP);

  logic              done_q;
  logic [ADDR_W-1:0] quo_q;
  logic [PRW-1:0]    product;

  assign product = PRW'(dividend_i) * PRW'(RECIP_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= ADDR_W'(product >> SH);
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
